>>> rtl/core/tknvs_pkg.sv
package tknvs_pkg;

	// Fixed widths of the interface fields and of the row accumulators.
	localparam int CFG_W      = 7;
	localparam int VALUE_W    = 16;
	localparam int RANK_W     = 4;
	localparam int IDX_OUT_W  = 16;
	localparam int LEN_W      = 8;
	localparam int ACC_W      = 40;
	localparam int SQ_W       = 2 * ACC_W;
	localparam int PROD_W     = SQ_W + ACC_W;
	localparam int DIGIT_W    = 8;
	localparam int MUL_STEPS  = ACC_W / DIGIT_W;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Item commands.
	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_REF   = 2'd1;
	localparam logic [1:0] CMD_EMIT  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Operand selection of the shared multiplier.
	localparam logic [1:0] SEL_SQ    = 2'd0;
	localparam logic [1:0] SEL_LEFT  = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;

	typedef struct packed {
		logic [1:0]                cmd;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [RANK_W-1:0]    rank;
		logic [IDX_OUT_W-1:0] euclid_index;
		logic                 euclid_valid;
		logic [IDX_OUT_W-1:0] cosine_index;
		logic                 cosine_valid;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic       q_write;
		logic       ref_capture;
		logic       ref_mul;
		logic       ref_acc;
		logic       ptr_clr;
		logic       ptr_inc;
		logic       euc_insert;
		logic       cos_insert;
		logic       mul_start;
		logic [1:0] mul_sel;
		logic       sq_load;
		logic       l_load;
		logic       row_finish;
		logic       out_load;
		logic       emit_clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic row_end;
		logic ptr_last;
		logic euc_hit;
		logic norm_zero;
		logic cos_quick_hit;
		logic cos_quick_miss;
		logic mul_done;
		logic cross_better;
		logic out_fire;
	} dp_stat_t;

endpackage

>>> rtl/core/top_k_nearest_vector_search.sv
// Channel   Direction  Handshake                    Payload
// config    in         cfg_write_en                 cfg_write_data (vector_length)
// item      in         item_valid / item_stall      item (cmd, value)
// result    out        result_valid / result_stall  result (rank, indexes, valids, last)
//
// A query element is written into the query memory as it is taken; a reference element
// passes through the read of the query memory, the registered products, then the
// accumulate. At a row end the Euclidean list is scanned one entry a cycle, and the
// cosine list then squares the dot product and compares it entry by entry, using the
// iterative 8-bit-digit multiplier. An emit offers the results one at a time, each
// held in the result register until taken. Reset clears all control state and
// empties both lists; the query memory holds no reset value.
module top_k_nearest_vector_search
	import tknvs_pkg::*;
#(
	parameter int MAX_LENGTH = 64,
	parameter int MAX_ROWS   = 65536,
	parameter int TOP_COUNT  = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [CFG_W-1:0] cfg_write_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	// The controller sequences each transfer; the datapath holds the query
	// memory, the accumulators, both ranked lists and the result register.
	ctl_cmd_t cmd;
	dp_stat_t stat;

	tknvs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_cmd   (item.cmd),
		.stat       (stat),
		.cmd        (cmd),
		.item_stall (item_stall)
	);

	tknvs_dp #(
		.MAX_LENGTH (MAX_LENGTH),
		.MAX_ROWS   (MAX_ROWS),
		.TOP_COUNT  (TOP_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item           (item),
		.result_stall   (result_stall),
		.cmd            (cmd),
		.stat           (stat),
		.result         (result),
		.result_valid   (result_valid)
	);

	// No item transfer is taken while a ranked result is on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item accepted during emit");

	// The final result of an emit carries the last rank.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> (result.rank == RANK_W'(TOP_COUNT - 1)))
		else $error("last flag on wrong rank");

	// After the final result transfer the block is ready for items again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.last) |=> !item_stall)
		else $error("block not ready after emit");

endmodule

>>> rtl/core/tknvs_ram.sv
module tknvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/tknvs_mul.sv
module tknvs_mul
	import tknvs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   a,
	input  logic [ACC_W-1:0]  b,
	output logic [PROD_W-1:0] prod,
	output logic              done
);

	localparam int STEP_W = $clog2(MUL_STEPS + 1);
	localparam int PART_W = SQ_W + DIGIT_W;

	logic [SQ_W-1:0]   a_q;
	logic [ACC_W-1:0]  b_q;
	logic [PROD_W-1:0] acc_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [PART_W-1:0] partial;

	// Multiplier digits are consumed from the top, one per cycle.
	assign partial = PART_W'(a_q) * PART_W'(b_q[ACC_W-1 -: DIGIT_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(partial);
			b_q   <= {b_q[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

>>> rtl/core/tknvs_ctrl.sv
module tknvs_ctrl
	import tknvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_cmd,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd,
	output logic       item_stall
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_EUC   = 4'd3;
	localparam logic [3:0] ST_COS   = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_CCMP  = 4'd6;
	localparam logic [3:0] ST_ML    = 4'd7;
	localparam logic [3:0] ST_MR    = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;
	localparam logic [3:0] ST_OLOAD = 4'd10;
	localparam logic [3:0] ST_OWAIT = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (item_cmd)
						CMD_QUERY: begin
							cmd.q_write = 1'b1;
						end
						CMD_REF: begin
							cmd.ref_capture = 1'b1;
							state_d         = ST_MUL;
						end
						CMD_EMIT: begin
							cmd.ptr_clr = 1'b1;
							state_d     = ST_OLOAD;
						end
						CMD_NOP: begin
						end
					endcase
				end
			end
			ST_MUL: begin
				cmd.ref_mul = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.ref_acc = 1'b1;
				if (stat.row_end) begin
					cmd.ptr_clr = 1'b1;
					state_d     = ST_EUC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EUC: begin
				if (stat.euc_hit) begin
					cmd.euc_insert = 1'b1;
					state_d        = ST_COS;
				end else if (stat.ptr_last) begin
					state_d = ST_COS;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			ST_COS: begin
				if (stat.norm_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = SEL_SQ;
					cmd.ptr_clr   = 1'b1;
					state_d       = ST_SQ;
				end
			end
			ST_SQ: begin
				if (stat.mul_done) begin
					cmd.sq_load = 1'b1;
					state_d     = ST_CCMP;
				end
			end
			ST_CCMP: begin
				if (stat.cos_quick_hit) begin
					cmd.cos_insert = 1'b1;
					state_d        = ST_FIN;
				end else if (stat.cos_quick_miss) begin
					if (stat.ptr_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.ptr_inc = 1'b1;
					end
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = SEL_LEFT;
					state_d       = ST_ML;
				end
			end
			ST_ML: begin
				if (stat.mul_done) begin
					cmd.l_load    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = SEL_RIGHT;
					state_d       = ST_MR;
				end
			end
			ST_MR: begin
				if (stat.mul_done) begin
					if (stat.cross_better) begin
						cmd.cos_insert = 1'b1;
						state_d        = ST_FIN;
					end else if (stat.ptr_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = ST_CCMP;
					end
				end
			end
			ST_FIN: begin
				cmd.row_finish = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_OLOAD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_OWAIT;
			end
			ST_OWAIT: begin
				if (stat.out_fire) begin
					if (stat.ptr_last) begin
						cmd.emit_clear = 1'b1;
						state_d        = ST_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = ST_OLOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/tknvs_dp.sv
module tknvs_dp
	import tknvs_pkg::*;
#(
	parameter int MAX_LENGTH = 64,
	parameter int MAX_ROWS   = 65536,
	parameter int TOP_COUNT  = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [CFG_W-1:0] cfg_write_data,
	input  item_t            item,
	input  logic             result_stall,
	input  ctl_cmd_t         cmd,
	output dp_stat_t         stat,
	output result_t          result,
	output logic             result_valid
);

	localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

	// Configuration and effective length.
	logic [CFG_W-1:0] vlen_q;
	logic [LEN_W-1:0] cfg_len;
	logic [LEN_W-1:0] eff_len;

	assign cfg_len = LEN_W'(vlen_q);
	assign eff_len = (vlen_q == '0) ? LEN_W'(1) :
	                 (cfg_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : cfg_len;

	// Positions.
	logic [AW-1:0]    qpos_q;
	logic [AW-1:0]    rpos_q;
	logic [AW-1:0]    q_addr;
	logic [LEN_W-1:0] q_next;
	logic [LEN_W-1:0] r_next;
	logic             row_end;

	assign q_addr  = (LEN_W'(qpos_q) >= eff_len) ? '0 : qpos_q;
	assign q_next  = LEN_W'(q_addr) + LEN_W'(1);
	assign r_next  = LEN_W'(rpos_q) + LEN_W'(1);
	assign row_end = (r_next >= eff_len);

	// Query store.
	logic [VALUE_W-1:0] ram_rdata;

	tknvs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_LENGTH)
	) u_query_ram (
		.clk   (clk),
		.we    (cmd.q_write),
		.waddr (q_addr),
		.wdata (item.value),
		.re    (cmd.ref_capture),
		.raddr (rpos_q),
		.rdata (ram_rdata)
	);

	// Element products.
	logic signed [VALUE_W-1:0]   value_q;
	logic signed [VALUE_W-1:0]   q_s;
	logic signed [VALUE_W:0]     diff;
	logic signed [2*VALUE_W+1:0] dd_full;
	logic signed [2*VALUE_W-1:0] qv_full;
	logic signed [2*VALUE_W-1:0] vv_full;
	logic [2*VALUE_W-1:0]        dd_s1;
	logic signed [2*VALUE_W-1:0] qv_s1;
	logic [2*VALUE_W-1:0]        vv_s1;

	assign q_s     = ram_rdata;
	assign diff    = q_s - value_q;
	assign dd_full = diff * diff;
	assign qv_full = q_s * value_q;
	assign vv_full = value_q * value_q;

	always_ff @(posedge clk) begin
		if (cmd.ref_capture) begin
			value_q <= item.value;
		end
		if (cmd.ref_mul) begin
			dd_s1 <= dd_full[2*VALUE_W-1:0];
			qv_s1 <= qv_full;
			vv_s1 <= vv_full;
		end
	end

	// Row accumulators and counters.
	logic [ACC_W-1:0]        euc_acc_q;
	logic signed [ACC_W-1:0] dot_acc_q;
	logic [ACC_W-1:0]        norm_acc_q;
	logic [ROW_W-1:0]        row_cnt_q;
	logic [IDX_W-1:0]        ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q     <= CFG_RESET;
			qpos_q     <= '0;
			rpos_q     <= '0;
			euc_acc_q  <= '0;
			dot_acc_q  <= '0;
			norm_acc_q <= '0;
			row_cnt_q  <= '0;
			ptr_q      <= '0;
		end else begin
			if (cfg_write_en) begin
				vlen_q <= cfg_write_data;
			end
			if (cmd.q_write) begin
				qpos_q <= (q_next >= eff_len) ? '0 : q_next[AW-1:0];
			end
			if (cmd.ref_acc) begin
				euc_acc_q  <= euc_acc_q + ACC_W'(dd_s1);
				dot_acc_q  <= dot_acc_q + ACC_W'(qv_s1);
				norm_acc_q <= norm_acc_q + ACC_W'(vv_s1);
				rpos_q     <= row_end ? '0 : r_next[AW-1:0];
			end
			if (cmd.row_finish || cmd.emit_clear) begin
				euc_acc_q  <= '0;
				dot_acc_q  <= '0;
				norm_acc_q <= '0;
				rpos_q     <= '0;
			end
			if (cmd.row_finish) begin
				row_cnt_q <= (row_cnt_q == ROW_W'(MAX_ROWS - 1)) ? '0
				             : row_cnt_q + ROW_W'(1);
			end
			if (cmd.emit_clear) begin
				row_cnt_q <= '0;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// Ranked lists.
	logic              e_valid_q [TOP_COUNT];
	logic [ACC_W-1:0]  e_dist_q  [TOP_COUNT];
	logic [ROW_W-1:0]  e_idx_q   [TOP_COUNT];
	logic              c_valid_q [TOP_COUNT];
	logic              c_pos_q   [TOP_COUNT];
	logic              c_neg_q   [TOP_COUNT];
	logic [SQ_W-1:0]   c_sq_q    [TOP_COUNT];
	logic [ACC_W-1:0]  c_norm_q  [TOP_COUNT];
	logic [ROW_W-1:0]  c_idx_q   [TOP_COUNT];

	logic [ACC_W-1:0] dot_bits;
	logic [ACC_W-1:0] dot_mag;
	logic             new_pos;
	logic             new_neg;
	logic [SQ_W-1:0]  sq_new_q;

	assign dot_bits = dot_acc_q;
	assign dot_mag  = dot_bits[ACC_W-1] ? (~dot_bits + ACC_W'(1)) : dot_bits;
	assign new_neg  = dot_bits[ACC_W-1];
	assign new_pos  = !dot_bits[ACC_W-1] && (dot_bits != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_COUNT; i++) begin
				e_valid_q[i] <= 1'b0;
				c_valid_q[i] <= 1'b0;
			end
		end else if (cmd.emit_clear) begin
			for (int i = 0; i < TOP_COUNT; i++) begin
				e_valid_q[i] <= 1'b0;
				c_valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.euc_insert) begin
				for (int i = TOP_COUNT - 1; i > 0; i--) begin
					if (i > int'(ptr_q)) begin
						e_valid_q[i] <= e_valid_q[i-1];
					end
				end
				e_valid_q[ptr_q] <= 1'b1;
			end
			if (cmd.cos_insert) begin
				for (int i = TOP_COUNT - 1; i > 0; i--) begin
					if (i > int'(ptr_q)) begin
						c_valid_q[i] <= c_valid_q[i-1];
					end
				end
				c_valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.euc_insert) begin
			for (int i = TOP_COUNT - 1; i > 0; i--) begin
				if (i > int'(ptr_q)) begin
					e_dist_q[i] <= e_dist_q[i-1];
					e_idx_q[i]  <= e_idx_q[i-1];
				end
			end
			e_dist_q[ptr_q] <= euc_acc_q;
			e_idx_q[ptr_q]  <= row_cnt_q;
		end
		if (cmd.cos_insert) begin
			for (int i = TOP_COUNT - 1; i > 0; i--) begin
				if (i > int'(ptr_q)) begin
					c_pos_q[i]  <= c_pos_q[i-1];
					c_neg_q[i]  <= c_neg_q[i-1];
					c_sq_q[i]   <= c_sq_q[i-1];
					c_norm_q[i] <= c_norm_q[i-1];
					c_idx_q[i]  <= c_idx_q[i-1];
				end
			end
			c_pos_q[ptr_q]  <= new_pos;
			c_neg_q[ptr_q]  <= new_neg;
			c_sq_q[ptr_q]   <= sq_new_q;
			c_norm_q[ptr_q] <= norm_acc_q;
			c_idx_q[ptr_q]  <= row_cnt_q;
		end
	end

	// Shared multiplier for the squared dot product and the exact cosine cross products.
	logic [SQ_W-1:0]   mul_a;
	logic [ACC_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_prod;
	logic              mul_done;
	logic [PROD_W-1:0] cross_l_q;

	always_comb begin
		case (cmd.mul_sel)
			SEL_SQ: begin
				mul_a = SQ_W'(dot_mag);
				mul_b = dot_mag;
			end
			SEL_LEFT: begin
				mul_a = sq_new_q;
				mul_b = c_norm_q[ptr_q];
			end
			SEL_RIGHT: begin
				mul_a = c_sq_q[ptr_q];
				mul_b = norm_acc_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tknvs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			sq_new_q <= mul_prod[SQ_W-1:0];
		end
		if (cmd.l_load) begin
			cross_l_q <= mul_prod;
		end
	end

	// Sign classes: negative 0, zero 1, positive 2.
	logic [1:0] new_cls;
	logic [1:0] ent_cls;

	assign new_cls = new_pos ? 2'd2 : (new_neg ? 2'd0 : 2'd1);
	assign ent_cls = c_pos_q[ptr_q] ? 2'd2 : (c_neg_q[ptr_q] ? 2'd0 : 2'd1);

	// Result register.
	logic                       result_valid_q;
	result_t                    result_q;
	logic [IDX_W+RANK_W-1:0]    rank_ext;
	logic [ROW_W+IDX_OUT_W-1:0] eidx_ext;
	logic [ROW_W+IDX_OUT_W-1:0] cidx_ext;
	logic                       out_fire;

	assign rank_ext = (IDX_W + RANK_W)'(ptr_q);
	assign eidx_ext = (ROW_W + IDX_OUT_W)'(e_idx_q[ptr_q]);
	assign cidx_ext = (ROW_W + IDX_OUT_W)'(c_idx_q[ptr_q]);
	assign out_fire = result_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (out_fire) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.rank         <= rank_ext[RANK_W-1:0];
			result_q.euclid_valid <= e_valid_q[ptr_q];
			result_q.euclid_index <= e_valid_q[ptr_q] ? eidx_ext[IDX_OUT_W-1:0] : '0;
			result_q.cosine_valid <= c_valid_q[ptr_q];
			result_q.cosine_index <= c_valid_q[ptr_q] ? cidx_ext[IDX_OUT_W-1:0] : '0;
			result_q.last         <= (ptr_q == IDX_W'(TOP_COUNT - 1));
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Status toward the controller.
	always_comb begin
		stat                = '0;
		stat.row_end        = row_end;
		stat.ptr_last       = (ptr_q == IDX_W'(TOP_COUNT - 1));
		stat.euc_hit        = !e_valid_q[ptr_q] || (euc_acc_q < e_dist_q[ptr_q]);
		stat.norm_zero      = (norm_acc_q == '0);
		stat.cos_quick_hit  = !c_valid_q[ptr_q] || (new_cls > ent_cls);
		stat.cos_quick_miss = c_valid_q[ptr_q] &&
		                      ((new_cls < ent_cls) || ((new_cls == ent_cls) && (new_cls == 2'd1)));
		stat.mul_done       = mul_done;
		stat.cross_better   = new_pos ? (cross_l_q > mul_prod) : (cross_l_q < mul_prod);
		stat.out_fire       = out_fire;
	end

endmodule

>>> tb/sv/testbench.sv
module testbench;
	import tknvs_pkg::*;

	// Build constants of the block under test.
	localparam int MAX_LENGTH = 64;
	localparam int TOP_COUNT  = 10;
	localparam int MAX_ROWS   = 65536;

	// Quiet time after the last result before the length register is changed or the
	// run ends. A row end may scan both lists with the iterative multiplier.
	localparam int SETTLE_CYCLES = 300;

	// The watchdog fires after this many cycles without any transfer.
	localparam int IDLE_LIMIT = 5000;

	localparam int RANDOM_ITEMS = 460;

	logic    clk;
	logic    arst_n;
	logic    cfg_write_en;
	logic    [CFG_W-1:0] cfg_write_data;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	top_k_nearest_vector_search dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------------
	// Predictor state: a copy of the query memory, the row accumulators and the
	// two ranked lists. The written mask keeps the stimulus from ever reading a
	// query entry that holds no value yet.
	// ------------------------------------------------------------------------
	typedef struct {
		bit              valid;
		longint unsigned sq_dist;
		int unsigned     row;
	} euclid_slot_t;

	typedef struct {
		bit              valid;
		longint          dot;
		longint unsigned norm;
		int unsigned     row;
	} cosine_slot_t;

	logic [CFG_W-1:0]     length_reg;
	logic signed [15:0]   query_mem [MAX_LENGTH];
	bit                   query_written [MAX_LENGTH];
	int unsigned          query_pos;
	int unsigned          ref_pos;
	int unsigned          row_number;
	longint unsigned      dist_acc;
	longint               dot_acc;
	longint unsigned      norm_acc;
	euclid_slot_t         euclid_rank [TOP_COUNT];
	cosine_slot_t         cosine_rank [TOP_COUNT];

	result_t ranking_queue [$];

	int  error_count;
	int  idle_cycles;
	bit  burst_mode;

	// Appends one expected result to the tail of the queue.
	function automatic void enqueue_result(result_t r);
		ranking_queue = {ranking_queue, r};
	endfunction

	function automatic int unsigned active_length();
		if (length_reg == 0)
			return 1;
		if (length_reg > MAX_LENGTH)
			return MAX_LENGTH;
		return length_reg;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic int sign_of(longint v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	// True when row a has a strictly higher cosine similarity than row b. The
	// similarity dot/|r| is compared without roots: by sign, then by dot^2 times
	// the norm of the other row.
	function automatic bit cosine_wins(longint da, longint unsigned na,
			longint db, longint unsigned nb);
		int               sa;
		int               sb;
		logic [127:0]     lhs;
		logic [127:0]     rhs;
		sa = sign_of(da);
		sb = sign_of(db);
		if (sa != sb)
			return sa > sb;
		if (sa == 0)
			return 1'b0;
		lhs = 128'(magnitude(da)) * 128'(magnitude(da)) * 128'(nb);
		rhs = 128'(magnitude(db)) * 128'(magnitude(db)) * 128'(na);
		return (sa > 0) ? (lhs > rhs) : (lhs < rhs);
	endfunction

	function automatic void clear_row_state();
		ref_pos  = 0;
		dist_acc = 0;
		dot_acc  = 0;
		norm_acc = 0;
	endfunction

	function automatic void clear_rankings();
		foreach (euclid_rank[i])
			euclid_rank[i] = '{1'b0, 0, 0};
		foreach (cosine_rank[i])
			cosine_rank[i] = '{1'b0, 0, 0, 0};
	endfunction

	// Places the finished row into both lists. A new row must beat a listed row
	// strictly, so on a tie the earlier row keeps its place.
	function automatic void rank_finished_row();
		int p;
		for (p = 0; p < TOP_COUNT; p++)
			if (!euclid_rank[p].valid || dist_acc < euclid_rank[p].sq_dist)
				break;
		if (p < TOP_COUNT) begin
			for (int i = TOP_COUNT - 1; i > p; i--)
				euclid_rank[i] = euclid_rank[i-1];
			euclid_rank[p] = '{1'b1, dist_acc, row_number};
		end
		// A row of all zeros has no direction and stays out of the cosine list.
		if (norm_acc != 0) begin
			for (p = 0; p < TOP_COUNT; p++)
				if (!cosine_rank[p].valid || cosine_wins(dot_acc, norm_acc,
						cosine_rank[p].dot, cosine_rank[p].norm))
					break;
			if (p < TOP_COUNT) begin
				for (int i = TOP_COUNT - 1; i > p; i--)
					cosine_rank[i] = cosine_rank[i-1];
				cosine_rank[p] = '{1'b1, dot_acc, norm_acc, row_number};
			end
		end
		row_number = (row_number + 1) % MAX_ROWS;
		clear_row_state();
	endfunction

	// Advances the predictor by one accepted item. An emit queues its ten ranked
	// results unless the caller has already typed them in.
	function automatic void predict_ranking(item_t it, bit queue_results);
		int unsigned len;
		longint      q;
		longint      v;
		result_t     r;
		len = active_length();
		v   = longint'(it.value);
		case (it.cmd)
			CMD_QUERY: begin
				if (query_pos >= len)
					query_pos = 0;
				query_mem[query_pos % MAX_LENGTH]     = it.value;
				query_written[query_pos % MAX_LENGTH] = 1'b1;
				query_pos++;
				if (query_pos >= len)
					query_pos = 0;
			end
			CMD_REF: begin
				q = longint'(query_mem[ref_pos % MAX_LENGTH]);
				dist_acc += longint'((q - v) * (q - v));
				dot_acc  += q * v;
				norm_acc += longint'(v * v);
				ref_pos++;
				if (ref_pos >= len)
					rank_finished_row();
			end
			CMD_EMIT: begin
				for (int k = 0; k < TOP_COUNT; k++) begin
					r.rank         = RANK_W'(k);
					r.euclid_valid = euclid_rank[k].valid;
					r.euclid_index = euclid_rank[k].valid ? IDX_OUT_W'(euclid_rank[k].row) : '0;
					r.cosine_valid = cosine_rank[k].valid;
					r.cosine_index = cosine_rank[k].valid ? IDX_OUT_W'(cosine_rank[k].row) : '0;
					r.last         = (k == TOP_COUNT - 1);
					if (queue_results)
						enqueue_result(r);
				end
				clear_rankings();
				row_number = 0;
				clear_row_state();
			end
			default: begin
			end
		endcase
	endfunction

	// Each side draws a random wait before each transfer, except during bursts where it
	// does not wait at all.
	function automatic int draw_wait();
		if ($urandom_range(0, 29) == 0)
			burst_mode = !burst_mode;
		return burst_mode ? 0 : $urandom_range(0, 18);
	endfunction

	// ------------------------------------------------------------------------
	// Item side. Inputs change on the falling edge; a transfer happens on the
	// rising edge where valid is high and stall is low.
	// ------------------------------------------------------------------------
	task automatic send_item(item_t it, bit queue_results);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       = it;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_ranking(it, queue_results);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	// The length register is only written while the block is idle: every expected
	// result has arrived and any row-end ranking has had time to finish.
	task automatic write_length(logic [CFG_W-1:0] len);
		while (ranking_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_write_en   = 1'b1;
		cfg_write_data = len;
		@(negedge clk);
		cfg_write_en = 1'b0;
		length_reg   = len;
	endtask

	// Typed-in ranking of an emit with both lists empty.
	task automatic queue_empty_ranking();
		result_t r;
		for (int k = 0; k < TOP_COUNT; k++) begin
			r = '0;
			r.rank = RANK_W'(k);
			r.last = (k == TOP_COUNT - 1);
			enqueue_result(r);
		end
	endtask

	// Random item: reference elements dominate, but only where the query entry to
	// be read has been written; otherwise the query is reloaded first.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0:       it.value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1:       it.value = 16'($signed($urandom_range(0, 4)) - 2);
			default: it.value = 16'($urandom);
		endcase
		if (!query_written[ref_pos % MAX_LENGTH] || pick < 15)
			it.cmd = CMD_QUERY;
		else if (pick < 18)
			it.cmd = CMD_EMIT;
		else if (pick < 21)
			it.cmd = CMD_NOP;
		else
			it.cmd = CMD_REF;
		return it;
	endfunction

	// Directed stimulus. A row either writes the length register or sends one
	// item; emit rows marked as typed carry a known empty ranking.
	typedef struct {
		bit               is_cfg;
		logic [CFG_W-1:0] len;
		logic [1:0]       cmd;
		logic [15:0]      value;
		bit               typed;
	} directed_row_t;

	directed_row_t directed_rows [] = '{
		// Emit right after reset: both lists are empty.
		'{1'b0, 7'd0,   CMD_EMIT,  16'h0000, 1'b1},
		// Length one with extreme values; a zero row stays out of the cosine list.
		'{1'b1, 7'd1,   CMD_NOP,   16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_QUERY, 16'h7fff, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h8000, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h7fff, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h8000, 1'b0},
		'{1'b0, 7'd0,   CMD_NOP,   16'hffff, 1'b0},
		'{1'b0, 7'd0,   CMD_EMIT,  16'hffff, 1'b0},
		// Zero query with length two: every cosine score ties.
		'{1'b1, 7'd2,   CMD_NOP,   16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_QUERY, 16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_QUERY, 16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h0001, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h0002, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'hfffe, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'hffff, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h0001, 1'b0},
		// Shrinking the length in the middle of a row ends that row at its next reference element.
		'{1'b1, 7'd0,   CMD_NOP,   16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_REF,   16'h1234, 1'b0},
		'{1'b0, 7'd0,   CMD_EMIT,  16'h0000, 1'b0},
		// Length above the maximum acts as the maximum.
		'{1'b1, 7'd127, CMD_NOP,   16'h0000, 1'b0},
		'{1'b0, 7'd0,   CMD_EMIT,  16'h0000, 1'b1}
	};

	// ------------------------------------------------------------------------
	// Result side and checking.
	// ------------------------------------------------------------------------
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			n = draw_wait();
			result_stall = (n != 0);
			repeat (n) @(negedge clk);
			result_stall = 1'b0;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (ranking_queue.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected result: %p", result);
			end else begin
				want = ranking_queue.pop_front();
				if (result.rank !== want.rank || result.euclid_index !== want.euclid_index ||
						result.euclid_valid !== want.euclid_valid ||
						result.cosine_index !== want.cosine_index ||
						result.cosine_valid !== want.cosine_valid || result.last !== want.last) begin
					error_count++;
					if (error_count <= 10)
						$display("Ranking mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// The watchdog counts cycles with no transfer on any channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		item_t it;
		error_count    = 0;
		idle_cycles    = 0;
		burst_mode     = 1'b0;
		arst_n         = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_write_data = '0;
		item_valid     = 1'b0;
		item           = '0;
		length_reg     = CFG_RESET;
		query_pos      = 0;
		row_number     = 0;
		foreach (query_written[i])
			query_written[i] = 1'b0;
		clear_row_state();
		clear_rankings();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_length(directed_rows[i].len);
			end else begin
				it.cmd   = directed_rows[i].cmd;
				it.value = directed_rows[i].value;
				if (directed_rows[i].typed)
					queue_empty_ranking();
				send_item(it, !directed_rows[i].typed);
			end
		end

		// Random part in phases. Short vectors dominate so that many rows finish;
		// the extremes of the length register come back now and then.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 60 == 0) begin
				case ($urandom_range(0, 5))
					0:       write_length(7'd0);
					1:       write_length(7'd127);
					2:       write_length(7'd64);
					default: write_length(CFG_W'($urandom_range(1, 6)));
				endcase
			end
			send_item(random_item(), 1'b1);
		end
		it.cmd   = CMD_EMIT;
		it.value = 16'h0000;
		send_item(it, 1'b1);

		while (ranking_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0 && ranking_queue.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/tknvs_pkg.sv
rtl/core/tknvs_ram.sv
rtl/core/tknvs_mul.sv
rtl/core/tknvs_ctrl.sv
rtl/core/tknvs_dp.sv
rtl/core/top_k_nearest_vector_search.sv
tb/sv/testbench.sv
